>>> design/dllm_pkg.sv
// ----------------------------------------------------------------------------
// dllm_pkg
// Shared types and constants for the doubly linked list manager.
// ----------------------------------------------------------------------------
package dllm_pkg;

    // default size of the node pool
    localparam int NODES_DEF = 16;

    // width of the command code field
    localparam int KIND_W = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_HEAD   = 4'd0,
        KIND_ADD_TAIL   = 4'd1,
        KIND_UNLINK     = 4'd2,
        KIND_POP_HEAD   = 4'd3,
        KIND_POP_TAIL   = 4'd4,
        KIND_MOVE_FRONT = 4'd5,
        KIND_HEAD       = 4'd6,
        KIND_TAIL       = 4'd7,
        KIND_PRED       = 4'd8,
        KIND_SUCC       = 4'd9
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_MISUSE = 2'd2
    } status_t;

endpackage

>>> design/dllm_ram.sv
// ----------------------------------------------------------------------------
// dllm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dllm_ram #(
    parameter int DEPTH = dllm_pkg::NODES_DEF,
    parameter int WIDTH = 1,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    import dllm_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/doubly_linked_list_manager.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// One doubly linked list over a pool of NODES node indices, driven by a
// command stream; each command returns one node index (or none) and a status.
// ----------------------------------------------------------------------------
// Flow: a command is taken only in ST_IDLE, which issues the link memory reads;
//   ST_EXEC evaluates, does the first writes and loads the result register,
//   waiting while an earlier result is still held; move to front of a
//   non-head node then adds ST_LINK (its relink needs a second write to the
//   next and prev link memories). A new command waits until the last is done.
// Reset: head/tail go to none at once; then a clearing pass zeroes the in-list
//   memory, during which no command is taken.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager #(
    parameter int NODES = dllm_pkg::NODES_DEF,
    localparam int IDX_W = $clog2(NODES),
    localparam int PTR_W = $clog2(NODES + 1),
    localparam int S_W   = ((dllm_pkg::KIND_W + IDX_W + 7) / 8) * 8,
    localparam int M_W   = ((PTR_W + 2 + 7) / 8) * 8
) (
    input  logic           clk,
    input  logic           rst_n,
    // command channel
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [S_W-1:0] s_tdata,   // kind[3:0], node[IDX_W-1:0], zero pad
    // result channel
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [M_W-1:0] m_tdata    // node_out[PTR_W-1:0], status[1:0], zero pad
);
    import dllm_pkg::*;

    localparam logic [PTR_W-1:0] NONE = PTR_W'(NODES);

    typedef enum logic [1:0] {
        ST_CLEAR,   // in-list memory clearing pass
        ST_IDLE,    // wait for a command, issue link reads
        ST_EXEC,    // evaluate, first writes, result
        ST_LINK     // move to front: relink at head
    } state_t;

    // ---------------------------------------------------------------- state
    state_t            state_reg,      state_next;
    logic [IDX_W-1:0]  clr_reg,        clr_next;
    logic [PTR_W-1:0]  head_reg,       head_next;
    logic [PTR_W-1:0]  tail_reg,       tail_next;
    logic [KIND_W-1:0] kind_reg,       kind_next;
    logic [PTR_W-1:0]  tgt_reg,        tgt_next;    // node the command works on
    logic              tgt_ok_reg,     tgt_ok_next; // tgt_reg is a real index
    logic              out_valid_reg,  out_valid_next;
    logic [PTR_W-1:0]  out_node_reg,   out_node_next;
    status_t           out_status_reg, out_status_next;

    // ------------------------------------------------------- memory ports
    logic             nx_we, pv_we, in_we;
    logic [IDX_W-1:0] nx_wa, pv_wa, in_wa;
    logic [PTR_W-1:0] nx_wd, pv_wd;
    logic             in_wd;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [PTR_W-1:0] rd_next, rd_prev;
    logic             rd_in;

    // -------------------------------------------------------- decode/exec
    logic [KIND_W-1:0] in_kind;
    logic [PTR_W-1:0]  in_node;
    logic [PTR_W-1:0]  sel_tgt;
    logic              accept;
    logic              exec_go;
    logic              listed;
    logic              is_head, is_tail;
    logic              do_detach;

    assign in_kind = s_tdata[KIND_W-1:0];
    assign in_node = PTR_W'(s_tdata[KIND_W +: IDX_W]);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // head and tail style commands work on the pointer, the rest on the node
    always_comb
    begin
        case (in_kind) inside
            KIND_POP_HEAD, KIND_HEAD: sel_tgt = head_reg;
            KIND_POP_TAIL, KIND_TAIL: sel_tgt = tail_reg;
            default:                  sel_tgt = in_node;
        endcase
    end

    assign rd_en   = accept && (sel_tgt < NONE);
    assign rd_addr = sel_tgt[IDX_W-1:0];

    // the result register must be free before a command may retire
    assign exec_go = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    assign listed  = tgt_ok_reg && rd_in;
    assign is_head = (head_reg == tgt_reg);
    assign is_tail = (tail_reg == tgt_reg);

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        kind_next       = kind_reg;
        tgt_next        = tgt_reg;
        tgt_ok_next     = tgt_ok_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_node_next   = out_node_reg;
        out_status_next = out_status_reg;

        nx_we = 1'b0;
        nx_wa = tgt_reg[IDX_W-1:0];
        nx_wd = NONE;
        pv_we = 1'b0;
        pv_wa = tgt_reg[IDX_W-1:0];
        pv_wd = NONE;
        in_we = 1'b0;
        in_wa = tgt_reg[IDX_W-1:0];
        in_wd = 1'b0;
        do_detach = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                in_we = 1'b1;
                in_wa = clr_reg;
                in_wd = 1'b0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next   = in_kind;
                    tgt_next    = sel_tgt;
                    tgt_ok_next = (sel_tgt < NONE);
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next      = ST_IDLE;
                    out_valid_next  = 1'b1;
                    out_node_next   = NONE;
                    out_status_next = STAT_MISUSE;

                    case (kind_reg)
                        KIND_ADD_HEAD:
                        begin
                            if (tgt_ok_reg && !rd_in)
                            begin
                                pv_we = (head_reg != NONE);
                                pv_wa = head_reg[IDX_W-1:0];
                                pv_wd = tgt_reg;
                                nx_we = 1'b1;
                                nx_wd = head_reg;
                                in_we = 1'b1;
                                in_wd = 1'b1;
                                head_next = tgt_reg;
                                if (tail_reg == NONE)
                                begin
                                    tail_next = tgt_reg;
                                end
                                out_node_next   = tgt_reg;
                                out_status_next = STAT_OK;
                            end
                        end

                        KIND_ADD_TAIL:
                        begin
                            if (tgt_ok_reg && !rd_in)
                            begin
                                nx_we = (tail_reg != NONE);
                                nx_wa = tail_reg[IDX_W-1:0];
                                nx_wd = tgt_reg;
                                pv_we = 1'b1;
                                pv_wd = tail_reg;
                                in_we = 1'b1;
                                in_wd = 1'b1;
                                tail_next = tgt_reg;
                                if (head_reg == NONE)
                                begin
                                    head_next = tgt_reg;
                                end
                                out_node_next   = tgt_reg;
                                out_status_next = STAT_OK;
                            end
                        end

                        KIND_UNLINK, KIND_POP_HEAD, KIND_POP_TAIL:
                        begin
                            if (listed)
                            begin
                                do_detach = 1'b1;
                                in_we = 1'b1;
                                in_wd = 1'b0;
                                out_node_next   = tgt_reg;
                                out_status_next = STAT_OK;
                            end
                            else if (kind_reg != KIND_UNLINK)
                            begin
                                out_status_next = STAT_EMPTY;
                            end
                        end

                        KIND_MOVE_FRONT:
                        begin
                            if (listed)
                            begin
                                if (!is_head)
                                begin
                                    // unhook now, relink at head next cycle
                                    do_detach  = 1'b1;
                                    state_next = ST_LINK;
                                end
                                out_node_next   = tgt_reg;
                                out_status_next = STAT_OK;
                            end
                        end

                        KIND_HEAD, KIND_TAIL:
                        begin
                            if (tgt_ok_reg)
                            begin
                                out_node_next   = tgt_reg;
                                out_status_next = STAT_OK;
                            end
                            else
                            begin
                                out_status_next = STAT_EMPTY;
                            end
                        end

                        KIND_PRED:
                        begin
                            if (listed)
                            begin
                                if (is_head)
                                begin
                                    out_status_next = STAT_EMPTY;
                                end
                                else
                                begin
                                    out_node_next   = rd_prev;
                                    out_status_next = STAT_OK;
                                end
                            end
                        end

                        KIND_SUCC:
                        begin
                            if (listed)
                            begin
                                if (is_tail)
                                begin
                                    out_status_next = STAT_EMPTY;
                                end
                                else
                                begin
                                    out_node_next   = rd_next;
                                    out_status_next = STAT_OK;
                                end
                            end
                        end

                        default:
                        begin
                            out_status_next = STAT_MISUSE;
                        end
                    endcase

                    // unhook tgt from its neighbors; the prev link of the head
                    // and the next link of the tail are never trusted
                    if (do_detach)
                    begin
                        if (is_head)
                        begin
                            head_next = is_tail ? NONE : rd_next;
                        end
                        else
                        begin
                            nx_we = 1'b1;
                            nx_wa = rd_prev[IDX_W-1:0];
                            nx_wd = is_tail ? NONE : rd_next;
                        end
                        if (is_tail)
                        begin
                            tail_next = is_head ? NONE : rd_prev;
                        end
                        else
                        begin
                            pv_we = 1'b1;
                            pv_wa = rd_next[IDX_W-1:0];
                            pv_wd = is_head ? NONE : rd_prev;
                        end
                    end
                end
            end

            ST_LINK:
            begin
                // list is non-empty here and head is not tgt
                pv_we = 1'b1;
                pv_wa = head_reg[IDX_W-1:0];
                pv_wd = tgt_reg;
                nx_we = 1'b1;
                nx_wd = head_reg;
                head_next  = tgt_reg;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            head_reg      <= NONE;
            tail_reg      <= NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        tgt_reg        <= tgt_next;
        tgt_ok_reg     <= tgt_ok_next;
        out_node_reg   <= out_node_next;
        out_status_reg <= out_status_next;
    end

    // ---------------------------------------------------------- memories
    dllm_ram #(.DEPTH(NODES), .WIDTH(PTR_W)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_wa),
        .wdata (nx_wd),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_next)
    );

    dllm_ram #(.DEPTH(NODES), .WIDTH(PTR_W)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_wa),
        .wdata (pv_wd),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_prev)
    );

    dllm_ram #(.DEPTH(NODES), .WIDTH(1)) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_wa),
        .wdata (in_wd),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_in)
    );

    // ------------------------------------------------------------ output
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_W'({out_status_reg, out_node_reg});

    // -------------------------------------------------------- assertions
    // an empty list has neither end; a non-empty one has both
    a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NONE) == (tail_reg == NONE))
        else $error("head and tail disagree on list emptiness");

    // pointers never leave the pool or none
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= NONE) && (tail_reg <= NONE))
        else $error("head or tail pointer out of range");

    // no command taken during the clearing pass
    a_no_cmd_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("command accepted while clearing");

    // every retired command leaves a result behind
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> m_tvalid)
        else $error("executed command produced no result");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the doubly linked list manager. Commands go in on
// the slave stream, and a scoreboard holds its own copy of the list. Each
// accepted command updates that copy and queues the node/status it should
// return. Each result transfer is compared against the oldest queued entry.
// ----------------------------------------------------------------------------
module tb_top;
    import dllm_pkg::*;

    localparam int NODES = NODES_DEF;
    localparam int IDX_W = $clog2(NODES);
    localparam int PTR_W = $clog2(NODES + 1);
    localparam int S_W   = ((KIND_W + IDX_W + 7) / 8) * 8;
    localparam int M_W   = ((PTR_W + 2 + 7) / 8) * 8;

    // "none" pointer value, one past the last node
    localparam logic [PTR_W-1:0] NO_NODE = PTR_W'(NODES);

    // command codes outside the defined set, both flagged as misuse
    localparam logic [KIND_W-1:0] KIND_BAD_LO = 4'd10;
    localparam logic [KIND_W-1:0] KIND_BAD_HI = 4'd15;

    typedef struct {
        logic [PTR_W-1:0] node_out;
        status_t          status;
    } list_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow list plus the queue of results still owed
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [PTR_W-1:0] nxt [NODES];
        logic [PTR_W-1:0] prv [NODES];
        bit               on_list [NODES];
        int               list_len;
        list_result_t     awaited_results [$];
        int               mismatch_count;

        function new();
            head = NO_NODE;
            tail = NO_NODE;
            list_len = 0;
            mismatch_count = 0;
            for (int i = 0; i < NODES; i++)
            begin
                nxt[i] = NO_NODE;
                prv[i] = NO_NODE;
                on_list[i] = 1'b0;
            end
        endfunction

        function void link_front(logic [PTR_W-1:0] n);
            if (head < NODES)
                prv[head] = n;
            nxt[n] = head;
            prv[n] = NO_NODE;
            head = n;
            if (tail == NO_NODE)
                tail = n;
            on_list[n] = 1'b1;
            list_len++;
        endfunction

        function void link_back(logic [PTR_W-1:0] n);
            if (tail < NODES)
                nxt[tail] = n;
            prv[n] = tail;
            nxt[n] = NO_NODE;
            tail = n;
            if (head == NO_NODE)
                head = n;
            on_list[n] = 1'b1;
            list_len++;
        endfunction

        function void unhook(logic [PTR_W-1:0] n);
            logic [PTR_W-1:0] p;
            logic [PTR_W-1:0] x;
            p = prv[n];
            x = nxt[n];
            if (p < NODES)
                nxt[p] = x;
            else
                head = x;
            if (x < NODES)
                prv[x] = p;
            else
                tail = p;
            nxt[n] = NO_NODE;
            prv[n] = NO_NODE;
            on_list[n] = 1'b0;
            list_len--;
        endfunction

        // applies one command to the shadow list, returns what the block owes
        function list_result_t apply_command(logic [KIND_W-1:0] kind,
                                             logic [IDX_W-1:0] node);
            list_result_t     r;
            logic [PTR_W-1:0] n;
            logic [PTR_W-1:0] t;
            bit               ok_node;
            bit               listed;
            n = PTR_W'(node);
            ok_node = (n < NODES);
            listed = ok_node && on_list[n];
            r.node_out = NO_NODE;
            r.status = STAT_MISUSE;
            case (kind)
                KIND_ADD_HEAD, KIND_ADD_TAIL:
                begin
                    if (ok_node && !listed)
                    begin
                        if (kind == KIND_ADD_HEAD)
                            link_front(n);
                        else
                            link_back(n);
                        r.node_out = n;
                        r.status = STAT_OK;
                    end
                end
                KIND_UNLINK:
                begin
                    if (listed)
                    begin
                        unhook(n);
                        r.node_out = n;
                        r.status = STAT_OK;
                    end
                end
                KIND_POP_HEAD, KIND_POP_TAIL:
                begin
                    t = (kind == KIND_POP_HEAD) ? head : tail;
                    if (t < NODES)
                    begin
                        unhook(t);
                        r.node_out = t;
                        r.status = STAT_OK;
                    end
                    else
                        r.status = STAT_EMPTY;
                end
                KIND_MOVE_FRONT:
                begin
                    if (listed)
                    begin
                        // head already in front: nothing moves
                        if (head != n)
                        begin
                            unhook(n);
                            link_front(n);
                        end
                        r.node_out = n;
                        r.status = STAT_OK;
                    end
                end
                KIND_HEAD, KIND_TAIL:
                begin
                    t = (kind == KIND_HEAD) ? head : tail;
                    if (t < NODES)
                    begin
                        r.node_out = t;
                        r.status = STAT_OK;
                    end
                    else
                        r.status = STAT_EMPTY;
                end
                KIND_PRED, KIND_SUCC:
                begin
                    if (listed)
                    begin
                        t = (kind == KIND_PRED) ? prv[n] : nxt[n];
                        if (t < NODES)
                        begin
                            r.node_out = t;
                            r.status = STAT_OK;
                        end
                        else
                            r.status = STAT_EMPTY;
                    end
                end
                default: ;  // undefined code, flagged and ignored
            endcase
            return r;
        endfunction

        function void note_command(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] node);
            awaited_results.push_back(apply_command(kind, node));
        endfunction

        function void check_result(logic [M_W-1:0] data);
            list_result_t want;
            logic [PTR_W-1:0] got_node;
            logic [1:0]       got_status;
            got_node = data[PTR_W-1:0];
            got_status = data[PTR_W+1:PTR_W];
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual node %0d status %0d",
                         $time, got_node, got_status);
                return;
            end
            want = awaited_results.pop_front();
            if (got_node !== want.node_out)
            begin
                mismatch_count++;
                $display("%0t: node_out mismatch, expected %0d, actual %0d",
                         $time, want.node_out, got_node);
            end
            if (got_status !== want.status)
            begin
                mismatch_count++;
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got_status);
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // a node that is on the list, or any node when the list is empty
        function logic [IDX_W-1:0] some_listed_node();
            logic [IDX_W-1:0] n;
            n = IDX_W'($urandom_range(0, NODES - 1));
            if (list_len == 0)
                return n;
            while (!on_list[n])
                n = IDX_W'($urandom_range(0, NODES - 1));
            return n;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;    // kind[3:0], node[IDX_W-1:0], zero pad
    logic           m_tvalid;
    logic           m_tready;
    logic [M_W-1:0] m_tdata;    // node_out[PTR_W-1:0], status[1:0], zero pad

    list_scoreboard sb = new();

    doubly_linked_list_manager #(
        .NODES (NODES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(64'd20_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // every result transfer is checked at the rising edge it happens on
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // ------------------------------------------------------------------------
    // Result side back-pressure: bursts of ready, short stalls, a few long
    // ones, and now and then a long calm stretch with no stall at all.
    // ------------------------------------------------------------------------
    initial
    begin : sink_pressure
        int r;
        int dur;
        m_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                m_tready <= 1'b1;
                dur = $urandom_range(100, 300);
            end
            else if (r < 65)
            begin
                m_tready <= 1'b1;
                dur = $urandom_range(1, 8);
            end
            else if (r < 92)
            begin
                m_tready <= 1'b0;
                dur = $urandom_range(1, 3);
            end
            else
            begin
                m_tready <= 1'b0;
                dur = $urandom_range(10, 40);
            end
            repeat (dur) @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // idle cycles after a transfer: mostly none or short, a few long
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // mode 0 grows the list, 1 drains it, 2 keeps it busy in the middle
    function automatic logic [KIND_W-1:0] pick_kind(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return KIND_W'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
        r = $urandom_range(0, 99);
        case (mode)
            0:
            begin
                if (r < 30) return KIND_ADD_HEAD;
                if (r < 60) return KIND_ADD_TAIL;
            end
            1:
            begin
                if (r < 20) return KIND_POP_HEAD;
                if (r < 40) return KIND_POP_TAIL;
                if (r < 55) return KIND_UNLINK;
            end
            default:
            begin
                if (r < 15) return KIND_ADD_HEAD;
                if (r < 30) return KIND_ADD_TAIL;
                if (r < 38) return KIND_UNLINK;
                if (r < 44) return KIND_POP_HEAD;
                if (r < 50) return KIND_POP_TAIL;
            end
        endcase
        return KIND_W'($urandom_range(KIND_ADD_HEAD, KIND_SUCC));
    endfunction

    // drive one command, wait for its transfer, then idle for gap cycles
    task automatic send_command(input logic [KIND_W-1:0] kind,
                                input logic [IDX_W-1:0] node, input int gap);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= S_W'({node, kind});
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_command(kind, node);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // sender holds off until the block has answered everything
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  node;
        int                mode;
        bit                calm;
        logic [KIND_W-1:0] dir_kind [25];
        logic [IDX_W-1:0]  dir_node [25];

        // directed sequence: empty-list reads and pops, misuse on unlisted
        // and already listed nodes, head/tail neighbors, moves of the head
        // and of other nodes, undefined codes, then drain to empty
        dir_kind = '{KIND_HEAD, KIND_TAIL, KIND_POP_HEAD, KIND_POP_TAIL,
                     KIND_PRED, KIND_SUCC, KIND_UNLINK, KIND_MOVE_FRONT,
                     KIND_ADD_HEAD, KIND_ADD_TAIL, KIND_ADD_HEAD, KIND_ADD_TAIL,
                     KIND_ADD_TAIL, KIND_PRED, KIND_SUCC, KIND_PRED,
                     KIND_SUCC, KIND_MOVE_FRONT, KIND_MOVE_FRONT, KIND_MOVE_FRONT,
                     KIND_BAD_LO, KIND_BAD_HI, KIND_UNLINK, KIND_POP_HEAD,
                     KIND_POP_TAIL};
        dir_node = '{4'd0, 4'd15, 4'd0, 4'd15,
                     4'd3, 4'd3, 4'd5, 4'd5,
                     4'd0, 4'd15, 4'd0, 4'd15,
                     4'd7, 4'd0, 4'd7, 4'd15,
                     4'd15, 4'd0, 4'd7, 4'd15,
                     4'd9, 4'd15, 4'd7, 4'd10,
                     4'd5};

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // the block runs its clearing pass first; send_command simply waits
        for (int i = 0; i < 25; i++)
            send_command(dir_kind[i], dir_node[i], pick_gap(i < 10));

        drain_results();

        for (int blk = 0; blk < 16; blk++)
        begin
            mode = $urandom_range(0, 2);
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 95; i++)
            begin
                kind = pick_kind(mode);
                // node-using commands mostly aim at listed nodes
                if ((kind == KIND_UNLINK || kind == KIND_MOVE_FRONT ||
                     kind == KIND_PRED || kind == KIND_SUCC) &&
                    $urandom_range(0, 99) < 80)
                    node = sb.some_listed_node();
                else
                    node = IDX_W'($urandom_range(0, NODES - 1));
                send_command(kind, node, pick_gap(calm));
            end
            if (blk == 5 || $urandom_range(0, 3) == 0)
                drain_results();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
design/dllm_pkg.sv
design/dllm_ram.sv
design/doubly_linked_list_manager.sv
bench/tb_top.sv
